>>> rtl/rgbhsl_pkg.sv
// Shared types and constants of the RGB/HSL saturation and lightness adjust block.
// Depends on nothing; every other file of the block imports it.
package rgbhsl_pkg;

  // Default number of fraction bits for hue, saturation and lightness.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned GAIN_W = 10;
  localparam int unsigned CFG_W  = 16;

  // Divider operand widths: dividend and divisor stay below 1531.
  localparam int unsigned DIV_W = 11;
  localparam int unsigned REM_W = 12;

  // Divider lanes: lightness, saturation and hue.
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned LANE_L    = 0;
  localparam int unsigned LANE_S    = 1;
  localparam int unsigned LANE_H    = 2;

  // Lightness divisor (2 * 255).
  localparam logic [DIV_W-1:0] LIGHT_DEN = 11'd510;

  // Register reset values, unsigned Q0.16.
  localparam logic [CFG_W-1:0] LIGHT_FLOOR_RST = 16'd1966;
  localparam logic [CFG_W-1:0] LIGHT_CEIL_RST  = 16'd49152;

  // Configuration register indexes.
  typedef enum logic {
    CFG_FLOOR = 1'b0,
    CFG_CEIL  = 1'b1
  } cfg_idx_e;

  // Segment of the hue circle that one output channel falls in.
  typedef enum logic [1:0] {
    SEG_RAMP,
    SEG_HIGH,
    SEG_LOW
  } seg_e;

  // Per-pixel data that travels alongside the divider.
  typedef struct packed {
    logic [GAIN_W-1:0] sat_gain;
    logic [GAIN_W-1:0] light_gain;
    logic              grey;
  } side_t;

endpackage

>>> rtl/rgbhsl_fwd.sv
// Front stage: channel maximum and minimum, and the dividends and divisors
// of lightness, saturation and hue. Depends on rgbhsl_pkg.
module rgbhsl_fwd import rgbhsl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [PIX_W-1:0]  red_i,
  input  logic [PIX_W-1:0]  green_i,
  input  logic [PIX_W-1:0]  blue_i,
  input  logic [GAIN_W-1:0] sat_gain_i,
  input  logic [GAIN_W-1:0] light_gain_i,
  output logic              vld_o,
  output logic [DIV_W-1:0]  dvd_o [NUM_LANES],
  output logic [DIV_W-1:0]  dvs_o [NUM_LANES],
  output side_t             side_o
);

  logic [PIX_W-1:0] mx, mn, d;
  logic [PIX_W:0]   sum;
  logic [DIV_W-1:0] d6, den, num;
  logic [DIV_W-1:0] dvd_d [NUM_LANES];
  logic [DIV_W-1:0] dvs_d [NUM_LANES];
  logic             vld_q;
  logic [DIV_W-1:0] dvd_q [NUM_LANES];
  logic [DIV_W-1:0] dvs_q [NUM_LANES];
  side_t            side_q;

  // Largest and smallest channel, their sum and spread.
  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    sum = {1'b0, mx} + {1'b0, mn};
    d   = mx - mn;
    d6  = DIV_W'({d, 2'b00}) + DIV_W'({d, 1'b0});
  end

  // Saturation divisor and hue numerator; the hue sum is never negative.
  always_comb begin
    if (sum > (PIX_W+1)'(255)) begin
      den = LIGHT_DEN - DIV_W'(sum);
    end else begin
      den = DIV_W'(sum);
    end
    if (mx == red_i) begin
      if (green_i >= blue_i) begin
        num = DIV_W'(green_i) - DIV_W'(blue_i);
      end else begin
        num = d6 - (DIV_W'(blue_i) - DIV_W'(green_i));
      end
    end else if (mx == green_i) begin
      num = DIV_W'(blue_i) + DIV_W'({d, 1'b0}) - DIV_W'(red_i);
    end else begin
      num = DIV_W'(red_i) + DIV_W'({d, 2'b00}) - DIV_W'(green_i);
    end
  end

  // Lane operands.
  always_comb begin
    dvd_d[LANE_L] = DIV_W'(sum);
    dvs_d[LANE_L] = LIGHT_DEN;
    dvd_d[LANE_S] = DIV_W'(d);
    dvs_d[LANE_S] = den;
    dvd_d[LANE_H] = num;
    dvs_d[LANE_H] = d6;
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    dvd_q                <= dvd_d;
    dvs_q                <= dvs_d;
    side_q.sat_gain      <= sat_gain_i;
    side_q.light_gain    <= light_gain_i;
    side_q.grey          <= (mx == mn);
  end

  assign vld_o  = vld_q;
  assign dvd_o  = dvd_q;
  assign dvs_o  = dvs_q;
  assign side_o = side_q;

endmodule

>>> rtl/rgbhsl_div.sv
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// Computes dividend * 2^FRAC_BITS / divisor for dividend <= divisor. Depends on rgbhsl_pkg.
module rgbhsl_div import rgbhsl_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic [DIV_W-1:0]     dvd_i [NUM_LANES],
  input  logic [DIV_W-1:0]     dvs_i [NUM_LANES],
  input  side_t                side_i,
  output logic                 vld_o,
  output logic [FRAC_BITS:0]   quo_o [NUM_LANES],
  output side_t                side_o
);

  localparam int unsigned QW  = FRAC_BITS + 1;
  localparam int unsigned NST = FRAC_BITS + 1;

  logic             vld_q  [NST];
  side_t            side_q [NST];
  logic [REM_W-1:0] rem_q  [NST][NUM_LANES];
  logic [DIV_W-1:0] dvs_q  [NST][NUM_LANES];
  logic [QW-1:0]    quo_q  [NST][NUM_LANES];

  logic             vld_s  [NST];
  side_t            side_s [NST];
  logic [REM_W-1:0] rem_s  [NST][NUM_LANES];
  logic [DIV_W-1:0] dvs_s  [NST][NUM_LANES];
  logic [QW-1:0]    quo_s  [NST][NUM_LANES];
  logic [REM_W-1:0] rem_d  [NST][NUM_LANES];
  logic [QW-1:0]    quo_d  [NST][NUM_LANES];

  // Stage sources: the ports for the first stage, the previous stage otherwise.
  always_comb begin
    vld_s[0]  = vld_i;
    side_s[0] = side_i;
    for (int j = 0; j < NUM_LANES; j++) begin
      rem_s[0][j] = REM_W'(dvd_i[j]);
      dvs_s[0][j] = dvs_i[j];
      quo_s[0][j] = '0;
    end
    for (int k = 1; k < NST; k++) begin
      vld_s[k]  = vld_q[k-1];
      side_s[k] = side_q[k-1];
      rem_s[k]  = rem_q[k-1];
      dvs_s[k]  = dvs_q[k-1];
      quo_s[k]  = quo_q[k-1];
    end
  end

  // One compare and subtract per stage and lane; the remainder is kept doubled.
  always_comb begin
    for (int k = 0; k < NST; k++) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        if (rem_s[k][j] >= REM_W'(dvs_s[k][j])) begin
          rem_d[k][j] = REM_W'((rem_s[k][j] - REM_W'(dvs_s[k][j])) << 1);
          quo_d[k][j] = {quo_s[k][j][QW-2:0], 1'b1};
        end else begin
          rem_d[k][j] = REM_W'(rem_s[k][j] << 1);
          quo_d[k][j] = {quo_s[k][j][QW-2:0], 1'b0};
        end
      end
    end
  end

  // Valid bits of all stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q <= vld_s;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    side_q <= side_s;
    rem_q  <= rem_d;
    dvs_q  <= dvs_s;
    quo_q  <= quo_d;
  end

  assign vld_o  = vld_q[NST-1];
  assign quo_o  = quo_q[NST-1];
  assign side_o = side_q[NST-1];

endmodule

>>> rtl/rgbhsl_back.sv
// Back end: gain scaling and clamping, HSL helpers and conversion to RGB,
// seven register stages. Depends on rgbhsl_pkg.
module rgbhsl_back import rgbhsl_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic [FRAC_BITS:0] light_i,
  input  logic [FRAC_BITS:0] sat_i,
  input  logic [FRAC_BITS:0] hue_i,
  input  side_t              side_i,
  input  logic [FRAC_BITS:0] lo_i,
  input  logic [FRAC_BITS:0] hi_i,
  output logic               vld_o,
  output logic [PIX_W-1:0]   red_o,
  output logic [PIX_W-1:0]   green_o,
  output logic [PIX_W-1:0]   blue_o
);

  localparam int unsigned W  = FRAC_BITS + 1;
  localparam int unsigned TW = FRAC_BITS + 3;
  localparam int unsigned MW = W + GAIN_W;
  localparam logic [W-1:0]  ONE  = W'(1) << FRAC_BITS;
  localparam logic [W-1:0]  HALF = ONE >> 1;
  localparam logic [TW-1:0] T1 = TW'(1) << FRAC_BITS;
  localparam logic [TW-1:0] T2 = TW'(2) << FRAC_BITS;
  localparam logic [TW-1:0] T3 = TW'(3) << FRAC_BITS;
  localparam logic [TW-1:0] T4 = TW'(4) << FRAC_BITS;
  localparam logic [TW-1:0] T6 = TW'(6) << FRAC_BITS;

  // Valid chain.
  logic [6:0] vld_q;

  // Stage 1: gain products.
  logic [MW-1:0]  lprod, sprod;
  logic [W+1:0]   lm1_q, sm1_q;
  logic [W-1:0]   h1_q;
  // Stage 2: clamped lightness and saturation, hue in sixths.
  logic [W-1:0]   l2_d, s2_d, l2_q, s2_q;
  logic [TW-1:0]  h6_d, h6_q;
  logic           zs2_q;
  // Stage 3: l * s and the three hue positions.
  logic [2*W-1:0] lsprod;
  logic [TW-1:0]  trs;
  logic [TW-1:0]  t3_d [3];
  logic [TW-1:0]  t3_q [3];
  logic [W-1:0]   l3_q, s3_q, ls3_q;
  logic           zs3_q;
  // Stage 4: helpers p and q.
  logic [W:0]     q_wide, l_dbl;
  logic [W-1:0]   q4_d, p4_d, q4_q, p4_q, l4_q;
  logic [TW-1:0]  t4_q [3];
  logic           zs4_q;
  // Stage 5: ramp products.
  logic [W-1:0]   diff;
  logic [W-1:0]   frac [3];
  logic [2*W-1:0] rprod [3];
  seg_e           seg5_d [3];
  seg_e           seg5_q [3];
  logic [W-1:0]   rp5_q [3];
  logic [W-1:0]   p5_q, q5_q, l5_q;
  logic           zs5_q;
  // Stage 6: channel fractions.
  logic [W-1:0]   f6_d [3];
  logic [W-1:0]   f6_q [3];
  // Stage 7: 8-bit channels.
  logic [W+7:0]   x255 [3];
  logic [8:0]     c9 [3];
  logic [PIX_W-1:0] c7_d [3];
  logic [PIX_W-1:0] c7_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], vld_i};
    end
  end

  // Stage 1: Q2.8 gains scale lightness and saturation; grey zeroes saturation.
  always_comb begin
    lprod = MW'(light_i) * MW'(side_i.light_gain);
    if (side_i.grey) begin
      sprod = '0;
    end else begin
      sprod = MW'(sat_i) * MW'(side_i.sat_gain);
    end
  end

  always_ff @(posedge clk_i) begin
    lm1_q <= lprod[MW-1:8];
    sm1_q <= sprod[MW-1:8];
    h1_q  <= hue_i;
  end

  // Stage 2: clamp lightness to the ceiling, then the floor; saturation to one.
  always_comb begin
    if (lm1_q > (W+2)'(hi_i)) begin
      l2_d = hi_i;
    end else begin
      l2_d = lm1_q[W-1:0];
    end
    if (l2_d < lo_i) begin
      l2_d = lo_i;
    end
    if (sm1_q > (W+2)'(ONE)) begin
      s2_d = ONE;
    end else begin
      s2_d = sm1_q[W-1:0];
    end
    h6_d = TW'(TW'(h1_q) << 2) + TW'(TW'(h1_q) << 1);
  end

  always_ff @(posedge clk_i) begin
    l2_q  <= l2_d;
    s2_q  <= s2_d;
    h6_q  <= h6_d;
    zs2_q <= (s2_d == '0);
  end

  // Stage 3: product l * s and the wrapped hue positions of red, green and blue.
  always_comb begin
    lsprod = (2*W)'(l2_q) * (2*W)'(s2_q);
    trs    = h6_q + T2;
    if (trs > T6) begin
      t3_d[0] = trs - T6;
    end else begin
      t3_d[0] = trs;
    end
    t3_d[1] = h6_q;
    if (h6_q < T2) begin
      t3_d[2] = h6_q + T4;
    end else begin
      t3_d[2] = h6_q - T2;
    end
  end

  always_ff @(posedge clk_i) begin
    l3_q  <= l2_q;
    s3_q  <= s2_q;
    ls3_q <= lsprod[FRAC_BITS +: W];
    t3_q  <= t3_d;
    zs3_q <= zs2_q;
  end

  // Stage 4: upper helper q and lower helper p, the latter floored at zero.
  always_comb begin
    if (l3_q < HALF) begin
      q_wide = {1'b0, l3_q} + {1'b0, ls3_q};
    end else begin
      q_wide = {1'b0, l3_q} + {1'b0, s3_q} - {1'b0, ls3_q};
    end
    q4_d  = q_wide[W-1:0];
    l_dbl = {l3_q, 1'b0};
    if (l_dbl < q_wide) begin
      p4_d = '0;
    end else begin
      p4_d = W'(l_dbl - q_wide);
    end
  end

  always_ff @(posedge clk_i) begin
    q4_q  <= q4_d;
    p4_q  <= p4_d;
    l4_q  <= l3_q;
    t4_q  <= t3_q;
    zs4_q <= zs3_q;
  end

  // Stage 5: pick each channel's segment and multiply the rising or falling ramp.
  always_comb begin
    diff = q4_q - p4_q;
    for (int c = 0; c < 3; c++) begin
      if (t4_q[c] < T1) begin
        seg5_d[c] = SEG_RAMP;
        frac[c]   = W'(t4_q[c]);
      end else if (t4_q[c] < T3) begin
        seg5_d[c] = SEG_HIGH;
        frac[c]   = '0;
      end else if (t4_q[c] < T4) begin
        seg5_d[c] = SEG_RAMP;
        frac[c]   = W'(T4 - t4_q[c]);
      end else begin
        seg5_d[c] = SEG_LOW;
        frac[c]   = '0;
      end
      rprod[c] = (2*W)'(diff) * (2*W)'(frac[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      rp5_q[c] <= rprod[c][FRAC_BITS +: W];
    end
    seg5_q <= seg5_d;
    p5_q   <= p4_q;
    q5_q   <= q4_q;
    l5_q   <= l4_q;
    zs5_q  <= zs4_q;
  end

  // Stage 6: channel fraction; zero saturation takes the grey path.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (zs5_q) begin
        f6_d[c] = l5_q;
      end else begin
        case (seg5_q[c])
          SEG_RAMP: f6_d[c] = p5_q + rp5_q[c];
          SEG_HIGH: f6_d[c] = q5_q;
          default:  f6_d[c] = p5_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    f6_q <= f6_d;
  end

  // Stage 7: fraction times 255, truncated and saturated to 8 bits.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      x255[c] = {f6_q[c], 8'b0} - (W+8)'(f6_q[c]);
      c9[c]   = x255[c][W+7:FRAC_BITS];
      if (c9[c] > 9'd255) begin
        c7_d[c] = 8'd255;
      end else begin
        c7_d[c] = c9[c][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c7_q <= c7_d;
  end

  assign vld_o   = vld_q[6];
  assign red_o   = c7_q[0];
  assign green_o = c7_q[1];
  assign blue_o  = c7_q[2];

endmodule

>>> rtl/rgb_hsl_saturation_lightness_adjust_top.sv
// Top level of the RGB/HSL saturation and lightness adjust block.
// Depends on rgbhsl_pkg, rgbhsl_fwd, rgbhsl_div and rgbhsl_back.
//
// Usage:
//   A pixel (red, green, blue) and its two Q2.8 gains are transferred at each
//   rising edge where start is high and busy is low. busy stays low, so a new
//   pixel may enter in every cycle.
//   The adjusted pixel appears on red/green/blue_out_o for one cycle with
//   strobe_o high. Throughput is one pixel per clock. The pipeline holds one
//   front stage, the divider with one quotient bit per stage over
//   FRAC_BITS + 1 stages, and seven back-end stages.
//   The receiver cannot stall; every result must be taken when it is strobed.
//   The configuration port writes the lightness floor (index 0) and ceiling
//   (index 1), Q0.16, at any edge where cfg_we_i is high; write only while no
//   pixel is in flight.
//   Reset clears all valid bits and sets floor and ceiling to 0.03 and 0.75.
module rgb_hsl_saturation_lightness_adjust_top import rgbhsl_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [PIX_W-1:0]  red_in_i,
  input  logic [PIX_W-1:0]  green_in_i,
  input  logic [PIX_W-1:0]  blue_in_i,
  input  logic [GAIN_W-1:0] sat_gain_i,
  input  logic [GAIN_W-1:0] light_gain_i,
  output logic              strobe_o,
  output logic [PIX_W-1:0]  red_out_o,
  output logic [PIX_W-1:0]  green_out_o,
  output logic [PIX_W-1:0]  blue_out_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned W     = FRAC_BITS + 1;
  localparam int unsigned UP    = (FRAC_BITS >= CFG_W) ? FRAC_BITS - CFG_W : 0;
  localparam int unsigned DN    = (FRAC_BITS < CFG_W) ? CFG_W - FRAC_BITS : 0;
  localparam int unsigned EXT_W = CFG_W + UP;

  logic [CFG_W-1:0] floor_q, ceil_q;
  logic [EXT_W-1:0] floor_ext, ceil_ext;
  logic [W-1:0]     lo, hi;

  logic             fwd_vld;
  logic [DIV_W-1:0] fwd_dvd [NUM_LANES];
  logic [DIV_W-1:0] fwd_dvs [NUM_LANES];
  side_t            fwd_side;
  logic             div_vld;
  logic [W-1:0]     div_quo [NUM_LANES];
  side_t            div_side;

  // Every cycle can take a pixel.
  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= LIGHT_FLOOR_RST;
      ceil_q  <= LIGHT_CEIL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FLOOR: floor_q <= cfg_data_i;
        CFG_CEIL:  ceil_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Rescale the Q0.16 limits to the internal fraction width.
  always_comb begin
    floor_ext = EXT_W'(EXT_W'(floor_q) << UP);
    ceil_ext  = EXT_W'(EXT_W'(ceil_q) << UP);
    lo        = W'(floor_ext >> DN);
    hi        = W'(ceil_ext >> DN);
  end

  rgbhsl_fwd u_fwd (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vld_i        (start & ~busy),
    .red_i        (red_in_i),
    .green_i      (green_in_i),
    .blue_i       (blue_in_i),
    .sat_gain_i   (sat_gain_i),
    .light_gain_i (light_gain_i),
    .vld_o        (fwd_vld),
    .dvd_o        (fwd_dvd),
    .dvs_o        (fwd_dvs),
    .side_o       (fwd_side)
  );

  rgbhsl_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (fwd_vld),
    .dvd_i  (fwd_dvd),
    .dvs_i  (fwd_dvs),
    .side_i (fwd_side),
    .vld_o  (div_vld),
    .quo_o  (div_quo),
    .side_o (div_side)
  );

  rgbhsl_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (div_vld),
    .light_i (div_quo[LANE_L]),
    .sat_i   (div_quo[LANE_S]),
    .hue_i   (div_quo[LANE_H]),
    .side_i  (div_side),
    .lo_i    (lo),
    .hi_i    (hi),
    .vld_o   (strobe_o),
    .red_o   (red_out_o),
    .green_o (green_out_o),
    .blue_o  (blue_out_o)
  );

endmodule
